### rtl/core/stack_with_linear_search_macros.svh
// ----------------------------------------------------------------------------
// Stack with linear search: assertion macros
// Concurrent assertion helpers used by the stack datapath.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_LINEAR_SEARCH_MACROS_SVH
`define STACK_WITH_LINEAR_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
`define SWS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SWS_ASSERT_SAME(label, clk, rst, ante, cons)
`define SWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/sws_pkg.sv
// ----------------------------------------------------------------------------
// Stack with linear search: package
// Shared codes, widths and the command and status bundles of the stack.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int DATA_W      = 32;
  localparam int POS_W       = 5;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - POS_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_SEARCH = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP_OUT,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic    take;
    logic    push;
    logic    rd_top;
    logic    pop;
    logic    scan_rd;
    logic    load;
    status_t status;
    logic    use_data;
    logic    use_pos;
  } ctrl_cmd_t;

  typedef struct packed {
    req_t req;
    logic empty;
    logic full;
    logic issue_done;
    logic hit;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/core/stack_with_linear_search.sv
// A push is done in S_EXEC, a pop reads the top in S_EXEC and returns it from
// S_POP_OUT, a search compares one entry per cycle top down in S_SCAN through
// the single read port of the entry memory. One request is in work at a time;
// the next is taken once the result sits in the output register.
// Reset empties the stack at once; entry contents are left as they were.
// ----------------------------------------------------------------------------
// Stack with linear search: top level
// Bounded LIFO stack of signed words with push, pop and top-down search.
// ----------------------------------------------------------------------------
module stack_with_linear_search import sws_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // value
  input  logic [REQ_W-1:0]       s_tuser,   // req_type
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // data, position, zero fill
  output logic [STATUS_W-1:0]    m_tuser    // status
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sws_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### rtl/core/sws_datapath.sv
// ----------------------------------------------------------------------------
// Stack with linear search: datapath
// Entry memory, fill count, scan counters and the output register.
// ----------------------------------------------------------------------------
`include "stack_with_linear_search_macros.svh"

module sws_datapath import sws_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ctrl_cmd_t              cmd,
  output dp_stat_t               stat,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // value
  input  logic [REQ_W-1:0]       s_tuser,   // req_type
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // data, position, zero fill
  output logic [STATUS_W-1:0]    m_tuser    // status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] value_q;
  req_t                     req_q;
  logic [CW-1:0]            count;
  logic [CW-1:0]            issue_k;
  logic [CW-1:0]            cmp_pos;
  logic                     cmp_valid;
  logic [CW-1:0]            top_idx;
  logic [CW-1:0]            scan_idx;
  logic [AW-1:0]            rd_addr;
  logic                     rd_en;
  status_t                  out_status;
  logic signed [DATA_W-1:0] out_data;
  logic [POS_W-1:0]         out_pos;

  assign top_idx  = count - 1'b1;
  assign scan_idx = count - 1'b1 - issue_k;
  assign rd_en    = cmd.rd_top || cmd.scan_rd;
  assign rd_addr  = cmd.rd_top ? top_idx[AW-1:0] : scan_idx[AW-1:0];

  assign stat.req        = req_q;
  assign stat.empty      = (count == '0);
  assign stat.full       = (count == CW'(DEPTH));
  assign stat.issue_done = (issue_k == count);
  assign stat.hit        = cmp_valid && (rdata == value_q);
  assign stat.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count[AW-1:0]] <= value_q;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      value_q <= $signed(s_tdata[DATA_W-1:0]);
      req_q   <= req_t'(s_tuser);
    end
    if (cmd.scan_rd) begin
      cmp_pos <= issue_k + 1'b1;
    end
    if (cmd.load) begin
      out_status <= cmd.status;
      out_data   <= cmd.use_data ? rdata : '0;
      out_pos    <= cmd.use_pos ? POS_W'(cmp_pos) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      issue_k   <= '0;
      cmp_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.push) begin
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        count <= count - 1'b1;
      end
      if (cmd.take) begin
        issue_k   <= '0;
        cmp_valid <= 1'b0;
      end else if (cmd.scan_rd) begin
        issue_k   <= issue_k + 1'b1;
        cmp_valid <= 1'b1;
      end
      if (cmd.load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_pos, out_data};
  assign m_tuser = out_status;

  `SWS_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))
  `SWS_ASSERT_SAME(a_load_free, clk, rst, cmd.load, !m_tvalid || m_tready)
  `SWS_ASSERT_NEXT(a_push_grows, clk, rst, cmd.push, count == $past(count) + 1'b1)
  `SWS_ASSERT_SAME(a_no_push_full, clk, rst, cmd.push, count != CW'(DEPTH))

endmodule

### rtl/core/sws_ctrl.sv
// ----------------------------------------------------------------------------
// Stack with linear search: controller
// Sequences push, pop and search requests over the datapath.
// ----------------------------------------------------------------------------
module sws_ctrl import sws_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.req)
          REQ_POP: begin
            if (!stat.empty) begin
              state_next = S_POP_OUT;
            end else if (stat.out_free) begin
              state_next = S_IDLE;
            end
          end
          REQ_SEARCH: state_next = S_SCAN;
          default: begin
            if (stat.out_free) begin
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_POP_OUT: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if ((stat.hit || stat.issue_done) && stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
      end
      S_EXEC: begin
        case (stat.req)
          REQ_PUSH: begin
            if (stat.out_free) begin
              cmd.load = 1'b1;
              if (stat.full) begin
                cmd.status = STAT_FULL;
              end else begin
                cmd.push = 1'b1;
              end
            end
          end
          REQ_POP: begin
            if (!stat.empty) begin
              cmd.rd_top = 1'b1;
            end else if (stat.out_free) begin
              cmd.load   = 1'b1;
              cmd.status = STAT_EMPTY;
            end
          end
          REQ_SEARCH: cmd.load = 1'b0;
          default: cmd.load = stat.out_free;
        endcase
      end
      S_POP_OUT: begin
        if (stat.out_free) begin
          cmd.load     = 1'b1;
          cmd.use_data = 1'b1;
          cmd.pop      = 1'b1;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          if (stat.out_free) begin
            cmd.load    = 1'b1;
            cmd.use_pos = 1'b1;
          end
        end else if (stat.issue_done) begin
          if (stat.out_free) begin
            cmd.load   = 1'b1;
            cmd.status = STAT_NOT_FOUND;
          end
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule
